@@ rtl/core/sqlm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqlm_pkg
// Shared types and constants of the squared level meter smoother: beat
// payloads, register indexes, reset values and controller commands.
// ----------------------------------------------------------------------------
package sqlm_pkg;

   localparam int SAMPLE_WIDTH = 12;
   localparam int LEVEL_WIDTH  = 24;
   localparam int COEF_WIDTH   = 24;
   localparam int CSR_IDX_BITS = 4;
   localparam int Q_BITS       = 24;

   // shared multiplier operands and product
   localparam int MUL_WIDTH  = LEVEL_WIDTH + 1;
   localparam int PROD_WIDTH = LEVEL_WIDTH + COEF_WIDTH + 1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_PEAK_COEF = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_AVG_COEF  = CSR_IDX_BITS'(1);

   localparam logic [COEF_WIDTH-1:0] PEAK_COEF_RESET = 24'hFEFA61;
   localparam logic [COEF_WIDTH-1:0] AVG_COEF_RESET  = 24'hFFFBA2;

   typedef struct packed {
      logic                    meter_channel;
      logic [SAMPLE_WIDTH-1:0] sample;
   } req_type;

   typedef struct packed {
      logic                   channel_out;
      logic [LEVEL_WIDTH-1:0] peak_level;
      logic [LEVEL_WIDTH-1:0] avg_level;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic square;
      logic peak;
      logic avg;
      logic wb;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } sts_type;

endpackage

@@ rtl/core/squared_level_meter_smoother_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// squared_level_meter_smoother_unit
// Per-sample squared peak and average level smoothing for a meter channel.
// ----------------------------------------------------------------------------
// Each accepted sample steps through accept, square, peak update, average
// update and write-back, sharing in turn the single 25x25 signed multiplier
// for the square and both coefficient products. The result sits in an
// output register, so the next sample is taken while a result still waits
// on rsp_ready. The user must write coefficients at csr_index 0 (peak) and 1
// (average) only while idle; the unit leaves this unchecked. Other indexes are ignored.
module squared_level_meter_smoother_unit #(
   parameter int NUM_CHANNELS = 2,
   parameter int SAMPLE_BITS  = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  sqlm_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output sqlm_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sqlm_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [sqlm_pkg::COEF_WIDTH-1:0]   csr_data
);

   sqlm_pkg::cmd_type cmd;
   sqlm_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   sqlm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sqlm_datapath #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

@@ rtl/core/sqlm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqlm_ctrl
// Sequencer that steps one sample through square, peak update, average
// update and write-back on the shared datapath multiplier.
// ----------------------------------------------------------------------------
module sqlm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sqlm_pkg::sts_type sts,
   output sqlm_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SQUARE,
      S_PEAK,
      S_AVG,
      S_WB
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;
   logic      ready_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: state_in = S_PEAK;
         S_PEAK:   state_in = S_AVG;
         S_AVG:    state_in = S_WB;
         S_WB: begin
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
      ready_in = (state_in == S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready   = ready_ff;
   assign cmd.capture = ready_ff && req_valid;
   assign cmd.square  = (state_ff == S_SQUARE);
   assign cmd.peak    = (state_ff == S_PEAK);
   assign cmd.avg     = (state_ff == S_AVG);
   assign cmd.wb      = (state_ff == S_WB) && sts.out_free;

endmodule

@@ rtl/core/sqlm_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqlm_datapath
// Coefficient registers, per-channel level stores, one shared signed
// multiplier and the result register.
// ----------------------------------------------------------------------------
module sqlm_datapath #(
   parameter int NUM_CHANNELS = 2,
   parameter int SAMPLE_BITS  = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [sqlm_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [sqlm_pkg::COEF_WIDTH-1:0]     csr_data,
   input  sqlm_pkg::req_type                   req_data,
   output sqlm_pkg::rsp_type                   rsp_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  sqlm_pkg::cmd_type                   cmd,
   output sqlm_pkg::sts_type                   sts
);

   localparam int SW = sqlm_pkg::SAMPLE_WIDTH;
   localparam int LW = sqlm_pkg::LEVEL_WIDTH;
   localparam int CW = sqlm_pkg::COEF_WIDTH;
   localparam int MW = sqlm_pkg::MUL_WIDTH;
   localparam int PW = sqlm_pkg::PROD_WIDTH;
   localparam int QB = sqlm_pkg::Q_BITS;
   localparam logic [SW-1:0] SAMPLE_MASK = SW'((SW+1)'(1) << SAMPLE_BITS) - SW'(1);

   logic [CW-1:0] peak_coef_ff;
   logic [CW-1:0] avg_coef_ff;
   logic [LW-1:0] peak_store_ff [2];
   logic [LW-1:0] avg_store_ff  [2];

   logic          ch_ff;
   logic [SW-1:0] smp_ff;
   logic [LW-1:0] sq_ff;
   logic [LW-1:0] cur_peak_ff;
   logic [LW-1:0] cur_avg_ff;
   logic [PW-1:0] prod_ff;
   logic [LW-1:0] peak_new_ff;
   sqlm_pkg::rsp_type rsp_ff;
   logic          rsp_valid_ff;

   logic                 idx;
   logic signed [MW-1:0] mul_a;
   logic signed [MW-1:0] mul_b;
   logic signed [2*MW-1:0] mul_p;
   logic [MW-1:0]        lvl_sum;
   logic [LW-1:0]        lvl_in;

   // channel index is 0 for a single channel, else the captured channel bit
   assign idx = (NUM_CHANNELS == 1) ? 1'b0 : ch_ff;

   always_comb begin
      mul_a = MW'(smp_ff);
      mul_b = MW'(smp_ff);
      if (cmd.peak) begin
         mul_a = $signed({1'b0, cur_peak_ff}) - $signed({1'b0, sq_ff});
         mul_b = $signed({1'b0, peak_coef_ff});
      end else if (cmd.avg) begin
         mul_a = $signed({1'b0, cur_avg_ff}) - $signed({1'b0, sq_ff});
         mul_b = $signed({1'b0, avg_coef_ff});
      end
   end

   assign mul_p   = mul_a * mul_b;
   // sq + floor(prod / 2^24), always within 24 bits
   assign lvl_sum = MW'({1'b0, sq_ff}) + prod_ff[PW-1:QB];
   assign lvl_in  = lvl_sum[LW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_coef_ff <= sqlm_pkg::PEAK_COEF_RESET;
         avg_coef_ff  <= sqlm_pkg::AVG_COEF_RESET;
      end else if (csr_valid) begin
         if (csr_index == sqlm_pkg::CSR_PEAK_COEF) begin
            peak_coef_ff <= csr_data;
         end else if (csr_index == sqlm_pkg::CSR_AVG_COEF) begin
            avg_coef_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_store_ff[0] <= '0;
         peak_store_ff[1] <= '0;
         avg_store_ff[0]  <= '0;
         avg_store_ff[1]  <= '0;
      end else begin
         if (cmd.avg) begin
            peak_store_ff[idx] <= lvl_in;
         end
         if (cmd.wb) begin
            avg_store_ff[idx] <= lvl_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ch_ff  <= req_data.meter_channel;
         smp_ff <= req_data.sample & SAMPLE_MASK;
      end
      if (cmd.square) begin
         sq_ff       <= mul_p[LW-1:0];
         cur_peak_ff <= peak_store_ff[idx];
         cur_avg_ff  <= avg_store_ff[idx];
      end
      if (cmd.peak || cmd.avg) begin
         prod_ff <= mul_p[PW-1:0];
      end
      if (cmd.avg) begin
         peak_new_ff <= lvl_in;
      end
      if (cmd.wb) begin
         rsp_ff.channel_out <= ch_ff;
         rsp_ff.peak_level  <= peak_new_ff;
         rsp_ff.avg_level   <= lvl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.wb) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

endmodule

@@ bench/tb_squared_level_meter_smoother_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_squared_level_meter_smoother_unit
// Self-checking bench for the squared peak and average level smoother. A
// short table of directed beats and coefficient writes opens the run. It
// covers the reset state, zero and full-scale coefficients, ignored register
// indexes and the extreme samples. Random beats follow under several
// coefficient settings and pacing phases. A behavioral model of both one-pole
// level trackers predicts each result that a directed row does not give, and
// each result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_squared_level_meter_smoother_unit;

   localparam int SAMPLE_WIDTH = sqlm_pkg::SAMPLE_WIDTH;
   localparam int LEVEL_WIDTH  = sqlm_pkg::LEVEL_WIDTH;
   localparam int COEF_WIDTH   = sqlm_pkg::COEF_WIDTH;
   localparam int CSR_IDX_BITS = sqlm_pkg::CSR_IDX_BITS;
   localparam int Q_BITS       = sqlm_pkg::Q_BITS;

   localparam int NUM_CHANNELS = 2;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int SEG_BEATS    = 180;
   localparam int NUM_SEGS     = 6;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX = '1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IDX_FIRST_UNUSED =
      sqlm_pkg::CSR_AVG_COEF + 1'b1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IDX_LAST         = '1;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type            kind;
      logic [CSR_IDX_BITS-1:0] index;
      logic [COEF_WIDTH-1:0]   value;
      sqlm_pkg::req_type       beat;
      bit                      typed;
      sqlm_pkg::rsp_type       want;
   } plan_row_type;

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   sqlm_pkg::req_type       req_data  = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   sqlm_pkg::rsp_type       rsp_data;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [COEF_WIDTH-1:0]   csr_data  = '0;

   logic [COEF_WIDTH-1:0]  peak_coef_cur = sqlm_pkg::PEAK_COEF_RESET;
   logic [COEF_WIDTH-1:0]  avg_coef_cur  = sqlm_pkg::AVG_COEF_RESET;
   logic [LEVEL_WIDTH-1:0] peak_track [NUM_CHANNELS];
   logic [LEVEL_WIDTH-1:0] avg_track  [NUM_CHANNELS];
   sqlm_pkg::rsp_type      level_expect_q [$];

   int send_gap_pct = 0;
   int stall_pct    = 0;
   int cycles       = 0;
   int mismatches   = 0;
   int beats_sent   = 0;
   int results_seen = 0;
   int csr_writes   = 0;

   squared_level_meter_smoother_unit #(
      .NUM_CHANNELS(NUM_CHANNELS),
      .SAMPLE_BITS (SAMPLE_WIDTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILURE");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // one-pole update: sq + floor((level - sq) * coef / 2^24)
   function automatic logic [LEVEL_WIDTH-1:0] smooth_level(
      logic [LEVEL_WIDTH-1:0] level, logic [LEVEL_WIDTH-1:0] sq, logic [COEF_WIDTH-1:0] coef);
      longint diff;
      longint prod;
      longint next;
      diff = longint'(level) - longint'(sq);
      prod = diff * longint'(coef);
      next = longint'(sq) + (prod >>> Q_BITS);
      if (next < 0) next = 0;
      if (next > longint'(LEVEL_MAX)) next = longint'(LEVEL_MAX);
      return next[LEVEL_WIDTH-1:0];
   endfunction

   function automatic sqlm_pkg::rsp_type predict_levels(sqlm_pkg::req_type beat);
      int                     ch;
      logic [LEVEL_WIDTH-1:0] sq;
      sqlm_pkg::rsp_type      r;
      ch = int'(beat.meter_channel) % NUM_CHANNELS;
      sq = LEVEL_WIDTH'(beat.sample) * LEVEL_WIDTH'(beat.sample);
      peak_track[ch] = smooth_level(peak_track[ch], sq, peak_coef_cur);
      avg_track[ch]  = smooth_level(avg_track[ch], sq, avg_coef_cur);
      r.channel_out = beat.meter_channel;
      r.peak_level  = peak_track[ch];
      r.avg_level   = avg_track[ch];
      return r;
   endfunction

   function automatic plan_row_type beat_row(logic ch, logic [SAMPLE_WIDTH-1:0] s, bit typed,
                                             logic [LEVEL_WIDTH-1:0] peak,
                                             logic [LEVEL_WIDTH-1:0] avg);
      plan_row_type row;
      row.kind               = ROW_BEAT;
      row.index              = '0;
      row.value              = '0;
      row.beat.meter_channel = ch;
      row.beat.sample        = s;
      row.typed              = typed;
      row.want.channel_out   = ch;
      row.want.peak_level    = peak;
      row.want.avg_level     = avg;
      return row;
   endfunction

   function automatic plan_row_type csr_row(logic [CSR_IDX_BITS-1:0] idx,
                                            logic [COEF_WIDTH-1:0] val);
      plan_row_type row;
      row       = beat_row(1'b0, '0, 1'b0, '0, '0);
      row.kind  = ROW_CSR;
      row.index = idx;
      row.value = val;
      return row;
   endfunction

   function automatic logic [SAMPLE_WIDTH-1:0] rand_sample();
      int pick;
      pick = $urandom_range(99);
      if (pick < 25) return '1;
      if (pick < 35) return '0;
      if (pick < 50) return SAMPLE_WIDTH'($urandom_range(63));
      return SAMPLE_WIDTH'($urandom_range(4095));
   endfunction

   function automatic logic [COEF_WIDTH-1:0] rand_coef();
      if ($urandom_range(1) == 0) return COEF_WIDTH'($urandom_range(24'hFFFFFF, 24'hF00000));
      return COEF_WIDTH'($urandom_range(24'hFFFFFF));
   endfunction

   task automatic send_beat(sqlm_pkg::req_type beat, bit typed, sqlm_pkg::rsp_type want);
      sqlm_pkg::rsp_type predicted;
      @(negedge clock);
      while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = predict_levels(beat);
      level_expect_q.push_back(typed ? want : predicted);
      beats_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (level_expect_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_BITS-1:0] idx, logic [COEF_WIDTH-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == sqlm_pkg::CSR_PEAK_COEF) peak_coef_cur = val;
      else if (idx == sqlm_pkg::CSR_AVG_COEF) avg_coef_cur = val;
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      sqlm_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (level_expect_q.size() == 0) begin
            $error("result beat with nothing expected: %p", rsp_data);
            mismatches++;
         end else begin
            want = level_expect_q.pop_front();
            if (rsp_data.channel_out !== want.channel_out) begin
               $error("channel_out expected %0d got %0d", want.channel_out,
                      rsp_data.channel_out);
               mismatches++;
            end
            if (rsp_data.peak_level !== want.peak_level) begin
               $error("peak_level expected %0d got %0d", want.peak_level,
                      rsp_data.peak_level);
               mismatches++;
            end
            if (rsp_data.avg_level !== want.avg_level) begin
               $error("avg_level expected %0d got %0d", want.avg_level,
                      rsp_data.avg_level);
               mismatches++;
            end
         end
      end
   end

   initial begin
      plan_row_type           plan [$];
      plan_row_type           row;
      sqlm_pkg::req_type      beat;
      logic [COEF_WIDTH-1:0]  peak_c;
      logic [COEF_WIDTH-1:0]  avg_c;
      logic [LEVEL_WIDTH-1:0] full_sq;
      int                     phase;

      full_sq = LEVEL_WIDTH'(4095 * 4095);
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         peak_track[ch] = '0;
         avg_track[ch]  = '0;
      end

      // levels start at zero, so a silent sample keeps them there
      plan.push_back(beat_row(1'b0, 12'h000, 1'b1, '0, '0));
      plan.push_back(beat_row(1'b1, 12'h000, 1'b1, '0, '0));
      plan.push_back(beat_row(1'b0, 12'h001, 1'b0, '0, '0));
      plan.push_back(beat_row(1'b1, 12'hFFF, 1'b0, '0, '0));
      // zero coefficient: level jumps to the square
      plan.push_back(csr_row(sqlm_pkg::CSR_PEAK_COEF, '0));
      plan.push_back(csr_row(sqlm_pkg::CSR_AVG_COEF, '0));
      plan.push_back(beat_row(1'b0, 12'hFFF, 1'b1, full_sq, full_sq));
      plan.push_back(beat_row(1'b1, 12'h001, 1'b1, 24'd1, 24'd1));
      plan.push_back(beat_row(1'b0, 12'h000, 1'b1, '0, '0));
      plan.push_back(beat_row(1'b1, 12'hAAA, 1'b1, 24'd7452900, 24'd7452900));
      plan.push_back(beat_row(1'b0, 12'h555, 1'b1, 24'd1863225, 24'd1863225));
      // unused register indexes leave the coefficients alone
      plan.push_back(csr_row(CSR_IDX_FIRST_UNUSED, '1));
      plan.push_back(csr_row(CSR_IDX_LAST, 24'h000001));
      plan.push_back(beat_row(1'b0, 12'h000, 1'b1, '0, '0));
      // full-scale coefficient: slowest possible tracking
      plan.push_back(csr_row(sqlm_pkg::CSR_PEAK_COEF, '1));
      plan.push_back(csr_row(sqlm_pkg::CSR_AVG_COEF, '1));
      plan.push_back(beat_row(1'b0, 12'hFFF, 1'b0, '0, '0));
      plan.push_back(beat_row(1'b1, 12'h000, 1'b0, '0, '0));
      plan.push_back(beat_row(1'b0, 12'h800, 1'b0, '0, '0));
      plan.push_back(csr_row(sqlm_pkg::CSR_PEAK_COEF, sqlm_pkg::PEAK_COEF_RESET));
      plan.push_back(csr_row(sqlm_pkg::CSR_AVG_COEF, sqlm_pkg::AVG_COEF_RESET));
      plan.push_back(beat_row(1'b1, 12'hFFF, 1'b0, '0, '0));
      plan.push_back(beat_row(1'b0, 12'hFFF, 1'b0, '0, '0));
      plan.push_back(beat_row(1'b1, 12'h7FF, 1'b0, '0, '0));

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         row = plan[i];
         if (row.kind == ROW_CSR) begin
            drain_results();
            csr_write(row.index, row.value);
         end else begin
            send_beat(row.beat, row.typed, row.want);
         end
      end

      for (int seg = 0; seg < NUM_SEGS; seg++) begin
         phase = seg % 4;
         case (phase)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 82; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 82; end
            default: begin send_gap_pct = 21; stall_pct = 21; end
         endcase
         case (seg)
            0: begin peak_c = sqlm_pkg::PEAK_COEF_RESET; avg_c = sqlm_pkg::AVG_COEF_RESET; end
            2: begin peak_c = '0; avg_c = '0; end
            3: begin peak_c = '1; avg_c = '1; end
            4: begin peak_c = 24'h000001; avg_c = 24'hFFFFFE; end
            default: begin peak_c = rand_coef(); avg_c = rand_coef(); end
         endcase
         drain_results();
         csr_write(sqlm_pkg::CSR_PEAK_COEF, peak_c);
         csr_write(sqlm_pkg::CSR_AVG_COEF, avg_c);
         for (int n = 0; n < SEG_BEATS; n++) begin
            if (n == SEG_BEATS / 2) drain_results();
            beat.meter_channel = 1'($urandom_range(1));
            beat.sample        = rand_sample();
            send_beat(beat, 1'b0, '0);
         end
      end

      drain_results();
      stall_pct = 0;
      $display("covered %0d sample beats and %0d level results, %0d coefficient writes,",
               beats_sent, results_seen, csr_writes);
      $display("four pacing mixes and coefficients from zero to full scale");
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
